>>> src/orsp_pkg.sv
package orsp_pkg;

    localparam int ADDR_BITS_DEFAULT = 24;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

    localparam logic [7:0] MAX_TEXT_RESET = 8'd30;
    localparam logic REG_MAX_TEXT = 1'b0;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] LETTER_H = 2'd0;
    localparam logic [1:0] LETTER_T = 2'd1;
    localparam logic [1:0] LETTER_M = 2'd2;
    localparam logic [1:0] LETTER_E = 2'd3;

    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_TEXT   = 3'd2;
    localparam logic [2:0] KIND_MOD    = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_ORDER    = 4'd1;
    localparam logic [3:0] ERR_HEX      = 4'd2;
    localparam logic [3:0] ERR_TOO_LONG = 4'd3;
    localparam logic [3:0] ERR_COUNT    = 4'd4;
    localparam logic [3:0] ERR_RANGE    = 4'd5;
    localparam logic [3:0] ERR_SIGN     = 4'd6;
    localparam logic [3:0] ERR_ZERO_NIB = 4'd7;
    localparam logic [3:0] ERR_TYPE     = 4'd8;
    localparam logic [3:0] ERR_MISSING  = 4'd9;

    localparam logic [8:0] ADDR_DIGITS  = 9'd6;
    localparam logic [8:0] COUNT_DIGITS = 9'd2;
    localparam logic [2:0] NAME_CHARS   = 3'd6;

    typedef enum logic [15:0] {
        PH_START  = 16'h0001,
        PH_BLANK  = 16'h0002,
        PH_SEP    = 16'h0004,
        PH_NAME   = 16'h0008,
        PH_GAP1   = 16'h0010,
        PH_HSTART = 16'h0020,
        PH_GAP2   = 16'h0040,
        PH_HLEN   = 16'h0080,
        PH_TADDR  = 16'h0100,
        PH_TCOUNT = 16'h0200,
        PH_TDATA  = 16'h0400,
        PH_MADDR  = 16'h0800,
        PH_MNIB   = 16'h1000,
        PH_MSIGN  = 16'h2000,
        PH_EADDR  = 16'h4000,
        PH_TAIL   = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic       ws;
        logic       sp_tab;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       cr;
        logic       lf;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [23:0] amount;
        logic [7:0]  data;
        logic [47:0] name;
        logic        sub;
        logic [3:0]  err;
        logic        last;
    } result_t;

endpackage

>>> src/orsp_front.sv
module orsp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         char_code,
    input  logic               end_of_file,
    output logic               item_valid,
    output orsp_pkg::item_t    item,
    input  logic               item_take
);

    orsp_pkg::item_t mem_reg [2];
    logic            wp_reg;
    logic            wp_next;
    logic            rp_reg;
    logic            rp_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    orsp_pkg::item_t cls;
    logic            push;

    // classify the character on the way in
    always_comb
    begin
        cls.ch      = char_code;
        cls.eof     = end_of_file;
        cls.sp_tab  = (char_code == orsp_pkg::CH_SPACE) || (char_code == orsp_pkg::CH_TAB);
        cls.ws      = cls.sp_tab || (char_code == orsp_pkg::CH_VT)
                      || (char_code == orsp_pkg::CH_FF);
        cls.cr      = (char_code == orsp_pkg::CH_CR);
        cls.lf      = (char_code == orsp_pkg::CH_LF);
        cls.hex_ok  = 1'b1;
        cls.hex_val = 4'd0;
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            cls.hex_val = 4'(char_code - 8'h30);
        end
        else if (char_code >= 8'h41 && char_code <= 8'h46)
        begin
            cls.hex_val = 4'(char_code - 8'h37);
        end
        else if (char_code >= 8'h61 && char_code <= 8'h66)
        begin
            cls.hex_val = 4'(char_code - 8'h57);
        end
        else
        begin
            cls.hex_ok = 1'b0;
        end
    end

    assign char_stall = (cnt_reg == 2'd2);
    assign push       = char_valid && !char_stall;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = item_take ? !rp_reg : rp_reg;
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, item_take});
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> src/orsp_core.sv
module orsp_core #(
    parameter int ADDR_BITS = orsp_pkg::ADDR_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  orsp_pkg::item_t    item,
    output logic               item_take,
    input  logic               room,
    input  logic [7:0]         max_text_bytes,
    output logic [1:0]         push_n,
    output orsp_pkg::result_t  res0,
    output orsp_pkg::result_t  res1
);

    localparam int A = ADDR_BITS;

    orsp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]   letter_reg, letter_next;
    logic [23:0]  field_reg, field_next;
    logic [8:0]   cc_reg, cc_next;
    logic [A-1:0] start_reg, start_next;
    logic [A-1:0] len_reg, len_next;
    logic [A:0]   end_reg, end_next;
    logic         hseen_reg, hseen_next;
    logic         eseen_reg, eseen_next;
    logic [3:0]   err_reg, err_next;
    logic [A-1:0] raddr_reg, raddr_next;
    logic [7:0]   count_reg, count_next;
    logic [3:0]   upper_reg, upper_next;
    logic [47:0]  name_reg, name_next;
    logic [2:0]   nlen_reg, nlen_next;
    logic         minus_reg, minus_next;

    function automatic logic [23:0] to24(input logic [A-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[23:0];
    endfunction

    function automatic logic in_prog(input logic [A-1:0] a, input logic [A-1:0] st,
                                     input logic [A-1:0] ln, input logic [A:0] en);
        return (ln == '0) || ((a >= st) && ((A+1)'(a) < en));
    endfunction

    assign item_take = item_valid && room;

    always_comb
    begin
        orsp_pkg::phase_t eff;
        logic             fresh;
        logic [23:0]      fv_base;
        logic [8:0]       cc_base;
        logic [23:0]      fv_new;
        logic [8:0]       cc_new;
        logic [31:0]      fv32;
        logic [A-1:0]     fv_addr;
        logic [3:0]       fail;
        logic [3:0]       fin_fail;
        logic             fin_n;
        orsp_pkg::result_t fin_res;
        orsp_pkg::result_t status;
        logic [3:0]       err_fin;
        logic [2:0]       nidx;

        phase_next  = phase_reg;
        letter_next = letter_reg;
        field_next  = field_reg;
        cc_next     = cc_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        end_next    = end_reg;
        hseen_next  = hseen_reg;
        eseen_next  = eseen_reg;
        err_next    = err_reg;
        raddr_next  = raddr_reg;
        count_next  = count_reg;
        upper_next  = upper_reg;
        name_next   = name_reg;
        nlen_next   = nlen_reg;
        minus_next  = minus_reg;
        push_n      = 2'd0;
        res0        = '0;
        res1        = '0;
        fail        = orsp_pkg::ERR_NONE;
        status      = '0;
        err_fin     = orsp_pkg::ERR_NONE;

        // line end handling
        fin_fail = orsp_pkg::ERR_NONE;
        fin_n    = 1'b0;
        fin_res  = '0;
        if (err_reg == orsp_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                orsp_pkg::PH_START, orsp_pkg::PH_BLANK:
                begin
                end
                orsp_pkg::PH_TDATA:
                begin
                    if (cc_reg != {count_reg, 1'b0})
                    begin
                        fin_fail = orsp_pkg::ERR_COUNT;
                    end
                    else
                    begin
                        fin_n           = 1'b1;
                        fin_res.kind    = orsp_pkg::KIND_TEXT;
                        fin_res.address = to24(raddr_reg);
                        fin_res.amount  = {16'd0, count_reg};
                    end
                end
                orsp_pkg::PH_TAIL:
                begin
                    fin_n = 1'b1;
                    if (letter_reg == orsp_pkg::LETTER_H)
                    begin
                        fin_res.kind    = orsp_pkg::KIND_HEADER;
                        fin_res.address = to24(start_reg);
                        fin_res.amount  = to24(len_reg);
                        fin_res.name    = name_reg;
                    end
                    else if (letter_reg == orsp_pkg::LETTER_M)
                    begin
                        fin_res.kind    = orsp_pkg::KIND_MOD;
                        fin_res.address = to24(raddr_reg);
                        fin_res.amount  = {16'd0, count_reg};
                        fin_res.sub     = minus_reg;
                    end
                    else
                    begin
                        fin_res.kind    = orsp_pkg::KIND_END;
                        fin_res.address = to24(raddr_reg);
                    end
                end
                default:
                begin
                    fin_fail = orsp_pkg::ERR_HEX;
                end
            endcase
        end

        // redirect phases that hand the character on to the next field
        eff   = phase_reg;
        fresh = 1'b0;
        unique case (phase_reg)
            orsp_pkg::PH_SEP:
            begin
                if (!item.sp_tab)
                begin
                    fresh = 1'b1;
                    unique case (letter_reg)
                        orsp_pkg::LETTER_H: eff = orsp_pkg::PH_NAME;
                        orsp_pkg::LETTER_T: eff = orsp_pkg::PH_TADDR;
                        orsp_pkg::LETTER_M: eff = orsp_pkg::PH_MADDR;
                        default:            eff = orsp_pkg::PH_EADDR;
                    endcase
                end
            end
            orsp_pkg::PH_NAME:
            begin
                if (!item.ws && nlen_reg >= orsp_pkg::NAME_CHARS)
                begin
                    fresh = 1'b1;
                    eff   = orsp_pkg::PH_HSTART;
                end
            end
            orsp_pkg::PH_GAP1:
            begin
                if (!item.ws)
                begin
                    fresh = 1'b1;
                    eff   = orsp_pkg::PH_HSTART;
                end
            end
            orsp_pkg::PH_GAP2:
            begin
                if (!item.ws)
                begin
                    fresh = 1'b1;
                    eff   = orsp_pkg::PH_HLEN;
                end
            end
            default:
            begin
            end
        endcase

        fv_base = fresh ? 24'd0 : field_reg;
        cc_base = fresh ? 9'd0 : cc_reg;
        fv_new  = {fv_base[19:0], item.hex_val};
        cc_new  = 9'(cc_base + 9'd1);
        fv32    = {8'd0, fv_new};
        fv_addr = fv32[A-1:0];
        nidx    = 3'(3'd5 - nlen_reg);

        if (item.eof)
        begin
            err_fin = (err_reg != orsp_pkg::ERR_NONE) ? err_reg : fin_fail;
            if (err_fin == orsp_pkg::ERR_NONE && !(hseen_reg && eseen_reg))
            begin
                err_fin = orsp_pkg::ERR_MISSING;
            end
            status.kind = orsp_pkg::KIND_STATUS;
            status.err  = err_fin;
            status.last = 1'b1;
            if (fin_n)
            begin
                res0   = fin_res;
                res1   = status;
                push_n = 2'd2;
            end
            else
            begin
                res0   = status;
                push_n = 2'd1;
            end
            phase_next  = orsp_pkg::PH_START;
            letter_next = orsp_pkg::LETTER_H;
            field_next  = '0;
            cc_next     = '0;
            start_next  = '0;
            len_next    = '0;
            end_next    = '0;
            hseen_next  = 1'b0;
            eseen_next  = 1'b0;
            err_next    = orsp_pkg::ERR_NONE;
            raddr_next  = '0;
            count_next  = '0;
            upper_next  = '0;
            name_next   = '0;
            nlen_next   = '0;
            minus_next  = 1'b0;
        end
        else if (item.cr || err_reg != orsp_pkg::ERR_NONE)
        begin
        end
        else if (item.lf)
        begin
            fail = fin_fail;
            if (fin_n)
            begin
                res0      = fin_res;
                res0.last = 1'b1;
                push_n    = 2'd1;
            end
            phase_next = orsp_pkg::PH_START;
            field_next = '0;
            cc_next    = '0;
            minus_next = 1'b0;
            nlen_next  = '0;
        end
        else
        begin
            phase_next = eff;
            field_next = fv_base;
            cc_next    = cc_base;
            unique case (eff)
                orsp_pkg::PH_START:
                begin
                    if (item.ws)
                    begin
                        phase_next = orsp_pkg::PH_BLANK;
                    end
                    else
                    begin
                        if (item.ch == orsp_pkg::CH_H)
                        begin
                            if (hseen_reg)
                            begin
                                fail = orsp_pkg::ERR_ORDER;
                            end
                            letter_next = orsp_pkg::LETTER_H;
                        end
                        else if (item.ch == orsp_pkg::CH_T || item.ch == orsp_pkg::CH_M
                                 || item.ch == orsp_pkg::CH_E)
                        begin
                            if (!hseen_reg || eseen_reg)
                            begin
                                fail = orsp_pkg::ERR_ORDER;
                            end
                            letter_next = (item.ch == orsp_pkg::CH_T) ? orsp_pkg::LETTER_T :
                                          (item.ch == orsp_pkg::CH_M) ? orsp_pkg::LETTER_M :
                                                                        orsp_pkg::LETTER_E;
                        end
                        else
                        begin
                            fail = orsp_pkg::ERR_TYPE;
                        end
                        name_next  = '0;
                        nlen_next  = '0;
                        phase_next = orsp_pkg::PH_SEP;
                        field_next = '0;
                        cc_next    = '0;
                    end
                end
                orsp_pkg::PH_BLANK:
                begin
                    if (!item.ws)
                    begin
                        fail = orsp_pkg::ERR_TYPE;
                    end
                end
                orsp_pkg::PH_NAME:
                begin
                    if (item.ws)
                    begin
                        phase_next = orsp_pkg::PH_GAP1;
                    end
                    else
                    begin
                        name_next[{nidx, 3'b000} +: 8] = item.ch;
                        nlen_next = 3'(nlen_reg + 3'd1);
                    end
                end
                orsp_pkg::PH_HSTART, orsp_pkg::PH_HLEN, orsp_pkg::PH_TADDR,
                orsp_pkg::PH_TCOUNT, orsp_pkg::PH_MADDR, orsp_pkg::PH_MNIB,
                orsp_pkg::PH_EADDR:
                begin
                    if (!item.hex_ok)
                    begin
                        fail = orsp_pkg::ERR_HEX;
                    end
                    else
                    begin
                        field_next = fv_new;
                        cc_next    = cc_new;
                        if (eff == orsp_pkg::PH_HSTART && cc_new >= orsp_pkg::ADDR_DIGITS)
                        begin
                            start_next = fv_addr;
                            phase_next = orsp_pkg::PH_GAP2;
                            field_next = '0;
                            cc_next    = '0;
                        end
                        if (eff == orsp_pkg::PH_HLEN && cc_new >= orsp_pkg::ADDR_DIGITS)
                        begin
                            len_next   = fv_addr;
                            end_next   = (A+1)'((A+1)'(start_reg) + (A+1)'(fv_addr));
                            hseen_next = 1'b1;
                            phase_next = orsp_pkg::PH_TAIL;
                            field_next = '0;
                            cc_next    = '0;
                        end
                        if ((eff == orsp_pkg::PH_TADDR || eff == orsp_pkg::PH_MADDR)
                            && cc_new >= orsp_pkg::ADDR_DIGITS)
                        begin
                            raddr_next = fv_addr;
                            phase_next = (eff == orsp_pkg::PH_TADDR) ? orsp_pkg::PH_TCOUNT
                                                                     : orsp_pkg::PH_MNIB;
                            field_next = '0;
                            cc_next    = '0;
                        end
                        if (eff == orsp_pkg::PH_TCOUNT && cc_new >= orsp_pkg::COUNT_DIGITS)
                        begin
                            count_next = fv_new[7:0];
                            if (fv_new[7:0] > max_text_bytes)
                            begin
                                fail = orsp_pkg::ERR_TOO_LONG;
                            end
                            else if (!in_prog(raddr_reg, start_reg, len_reg, end_reg)
                                     || (len_reg != '0 && (A+1)'((A+1)'(raddr_reg)
                                         + (A+1)'(fv_new[7:0])) > end_reg))
                            begin
                                fail = orsp_pkg::ERR_RANGE;
                            end
                            phase_next = orsp_pkg::PH_TDATA;
                            field_next = '0;
                            cc_next    = '0;
                        end
                        if (eff == orsp_pkg::PH_MNIB && cc_new >= orsp_pkg::COUNT_DIGITS)
                        begin
                            count_next = fv_new[7:0];
                            phase_next = orsp_pkg::PH_MSIGN;
                            field_next = '0;
                            cc_next    = '0;
                        end
                        if (eff == orsp_pkg::PH_EADDR && cc_new >= orsp_pkg::ADDR_DIGITS)
                        begin
                            raddr_next = fv_addr;
                            if (!in_prog(fv_addr, start_reg, len_reg, end_reg))
                            begin
                                fail = orsp_pkg::ERR_RANGE;
                            end
                            else
                            begin
                                eseen_next = 1'b1;
                            end
                            phase_next = orsp_pkg::PH_TAIL;
                            field_next = '0;
                            cc_next    = '0;
                        end
                    end
                end
                orsp_pkg::PH_TDATA:
                begin
                    if (cc_reg >= {count_reg, 1'b0})
                    begin
                        fail = orsp_pkg::ERR_COUNT;
                    end
                    else if (!item.hex_ok)
                    begin
                        fail = orsp_pkg::ERR_HEX;
                    end
                    else
                    begin
                        cc_next = 9'(cc_reg + 9'd1);
                        if (!cc_reg[0])
                        begin
                            upper_next = item.hex_val;
                        end
                        else
                        begin
                            res0.kind    = orsp_pkg::KIND_BYTE;
                            res0.address = to24(A'(raddr_reg + A'(cc_reg[8:1])));
                            res0.data    = {upper_reg, item.hex_val};
                            res0.last    = 1'b1;
                            push_n       = 2'd1;
                        end
                    end
                end
                orsp_pkg::PH_MSIGN:
                begin
                    if (item.ch != orsp_pkg::CH_PLUS && item.ch != orsp_pkg::CH_MINUS)
                    begin
                        fail = orsp_pkg::ERR_SIGN;
                    end
                    else if (count_reg == 8'd0)
                    begin
                        fail = orsp_pkg::ERR_ZERO_NIB;
                    end
                    else if (!in_prog(raddr_reg, start_reg, len_reg, end_reg))
                    begin
                        fail = orsp_pkg::ERR_RANGE;
                    end
                    minus_next = (item.ch == orsp_pkg::CH_MINUS);
                    phase_next = orsp_pkg::PH_TAIL;
                    field_next = '0;
                    cc_next    = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (!item.eof && err_reg == orsp_pkg::ERR_NONE)
        begin
            err_next = fail;
        end

        if (!item_take)
        begin
            phase_next  = phase_reg;
            letter_next = letter_reg;
            field_next  = field_reg;
            cc_next     = cc_reg;
            start_next  = start_reg;
            len_next    = len_reg;
            end_next    = end_reg;
            hseen_next  = hseen_reg;
            eseen_next  = eseen_reg;
            err_next    = err_reg;
            raddr_next  = raddr_reg;
            count_next  = count_reg;
            upper_next  = upper_reg;
            name_next   = name_reg;
            nlen_next   = nlen_reg;
            minus_next  = minus_reg;
            push_n      = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= orsp_pkg::PH_START;
            letter_reg <= orsp_pkg::LETTER_H;
            field_reg  <= '0;
            cc_reg     <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            end_reg    <= '0;
            hseen_reg  <= 1'b0;
            eseen_reg  <= 1'b0;
            err_reg    <= orsp_pkg::ERR_NONE;
            raddr_reg  <= '0;
            count_reg  <= '0;
            upper_reg  <= '0;
            name_reg   <= '0;
            nlen_reg   <= '0;
            minus_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            letter_reg <= letter_next;
            field_reg  <= field_next;
            cc_reg     <= cc_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            end_reg    <= end_next;
            hseen_reg  <= hseen_next;
            eseen_reg  <= eseen_next;
            err_reg    <= err_next;
            raddr_reg  <= raddr_next;
            count_reg  <= count_next;
            upper_reg  <= upper_next;
            name_reg   <= name_next;
            nlen_reg   <= nlen_next;
            minus_reg  <= minus_next;
        end
    end

`ifndef SYNTHESIS
    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> room)
        else $error("request taken without output room");

    a_push_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> item_take)
        else $error("result pushed without a request");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.eof) |=> (err_reg == orsp_pkg::ERR_NONE
                                     && phase_reg == orsp_pkg::PH_START && !hseen_reg))
        else $error("state not cleared after end of file");
`endif

endmodule

>>> src/orsp_outq.sv
module orsp_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_n,
    input  orsp_pkg::result_t  res0,
    input  orsp_pkg::result_t  res1,
    output logic               room,
    output logic               result_valid,
    input  logic               result_stall,
    output orsp_pkg::result_t  head
);

    localparam int PB = orsp_pkg::OUTQ_PTR_BITS;
    localparam int CB = orsp_pkg::OUTQ_CNT_BITS;

    orsp_pkg::result_t mem_reg [orsp_pkg::OUTQ_DEPTH];
    logic [PB-1:0]     wp_reg, wp_next;
    logic [PB-1:0]     rp_reg, rp_next;
    logic [CB-1:0]     cnt_reg, cnt_next;
    logic              pop;
    logic [PB-1:0]     wp_plus1;

    assign room         = (cnt_reg <= CB'(orsp_pkg::OUTQ_DEPTH - 2));
    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign head         = mem_reg[rp_reg];
    assign wp_plus1     = PB'(wp_reg + PB'(1));

    always_comb
    begin
        wp_next  = PB'(wp_reg + PB'(push_n));
        rp_next  = pop ? PB'(rp_reg + PB'(1)) : rp_reg;
        cnt_next = CB'(cnt_reg + CB'(push_n) - CB'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wp_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wp_plus1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> src/object_record_stream_parser.sv
// Parses an object program one character per request and streams out decoded
// text bytes, one result per finished record and a final status at end of file.
// One character is taken every cycle unless char_stall is raised: a two-entry
// input queue feeds a combinational parse step, and its results go into a
// four-entry output queue. A character causes at most two results; the parse
// step waits whenever the output queue has room for fewer than two, so the rate
// holds at one request per cycle as long as results are taken as fast as they
// appear. Configuration writes may only be made while the block is idle.
module object_record_stream_parser #(
    parameter int ADDR_BITS = orsp_pkg::ADDR_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_file,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  result_kind,
    output logic [23:0] address,
    output logic [23:0] amount,
    output logic [7:0]  data_byte,
    output logic [47:0] program_name,
    output logic        subtract,
    output logic [3:0]  error_code,
    output logic        last_of_run
);

    logic [7:0]        max_text_reg;
    logic [7:0]        max_text_next;
    logic              item_valid;
    orsp_pkg::item_t   item;
    logic              item_take;
    logic              room;
    logic [1:0]        push_n;
    orsp_pkg::result_t res0;
    orsp_pkg::result_t res1;
    orsp_pkg::result_t head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == orsp_pkg::REG_MAX_TEXT) ? {24'd0, max_text_reg} : 32'd0;

    always_comb
    begin
        max_text_next = max_text_reg;
        if (psel && penable && pwrite && pready && paddr[2] == orsp_pkg::REG_MAX_TEXT)
        begin
            max_text_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_text_reg <= orsp_pkg::MAX_TEXT_RESET;
        end
        else
        begin
            max_text_reg <= max_text_next;
        end
    end

    orsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_code   (char_code),
        .end_of_file (end_of_file),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    orsp_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take),
        .room           (room),
        .max_text_bytes (max_text_reg),
        .push_n         (push_n),
        .res0           (res0),
        .res1           (res1)
    );

    orsp_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_n       (push_n),
        .res0         (res0),
        .res1         (res1),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign result_kind  = head.kind;
    assign address      = head.address;
    assign amount       = head.amount;
    assign data_byte    = head.data;
    assign program_name = head.name;
    assign subtract     = head.sub;
    assign error_code   = head.err;
    assign last_of_run  = head.last;

endmodule

>>> tb/sv/object_record_stream_parser_tb.sv
module object_record_stream_parser_tb;

    class parse_scoreboard;
        orsp_pkg::result_t expected_q[$];
        int                errors;
        logic [7:0]        max_text;
        orsp_pkg::phase_t  ph;
        logic [1:0]        letter;
        logic [23:0]       fv;
        logic [8:0]        cnt;
        logic [23:0]       pstart;
        logic [23:0]       plen;
        bit                hseen;
        bit                eseen;
        logic [3:0]        err;
        logic [23:0]       raddr;
        logic [7:0]        rcount;
        logic [3:0]        upn;
        logic [47:0]       nbuf;
        logic [2:0]        nlen;
        bit                lead;
        bit                minus;

        function void clear_state();
            ph = orsp_pkg::PH_START; letter = orsp_pkg::LETTER_H; fv = '0; cnt = '0;
            pstart = '0; plen = '0; hseen = 0; eseen = 0; err = orsp_pkg::ERR_NONE;
            raddr = '0; rcount = '0; upn = '0; nbuf = '0; nlen = '0; lead = 0; minus = 0;
        endfunction

        function new();
            errors = 0;
            max_text = orsp_pkg::MAX_TEXT_RESET;
            clear_state();
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == orsp_pkg::CH_SPACE || c == orsp_pkg::CH_TAB
                   || c == orsp_pkg::CH_VT || c == orsp_pkg::CH_FF;
        endfunction

        function logic [4:0] hexv(logic [7:0] c);
            if (c >= "0" && c <= "9") return 5'(c - "0");
            if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
            if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
            return 5'd16;
        endfunction

        function void fail(logic [3:0] code);
            if (err == orsp_pkg::ERR_NONE) err = code;
        endfunction

        function void push(logic [2:0] k, logic [23:0] a, logic [23:0] amt,
                           logic [7:0] b, logic [47:0] nm, bit s, logic [3:0] e);
            orsp_pkg::result_t r;
            r.kind = k; r.address = a; r.amount = amt; r.data = b; r.name = nm;
            r.sub = s; r.err = e; r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function bit in_program(longint unsigned a, bit incl);
            longint unsigned top;
            top = longint'(pstart) + longint'(plen);
            if (plen == '0) return 1;
            if (a < pstart) return 0;
            return incl ? (a <= top) : (a < top);
        endfunction

        function void next_field(orsp_pkg::phase_t p);
            ph = p; fv = '0; cnt = '0;
        endfunction

        function bit take_hex(logic [7:0] c, int len);
            logic [4:0] d;
            d = hexv(c);
            if (d > 5'd15)
            begin
                fail(orsp_pkg::ERR_HEX);
                return 0;
            end
            fv = {fv[19:0], d[3:0]};
            cnt++;
            return int'(cnt) >= len;
        endfunction

        function void take_char(logic [7:0] c);
            bit again;
            logic [4:0] d;
            logic [23:0] a;
            again = 1;
            while (again)
            begin
                again = 0;
                case (ph)
                    orsp_pkg::PH_START:
                    begin
                        if (is_ws(c))
                        begin
                            ph = orsp_pkg::PH_BLANK;
                            lead = 1;
                        end
                        else
                        begin
                            if (c == orsp_pkg::CH_H)
                            begin
                                if (hseen) fail(orsp_pkg::ERR_ORDER);
                                letter = orsp_pkg::LETTER_H;
                            end
                            else if (c == orsp_pkg::CH_T || c == orsp_pkg::CH_M
                                     || c == orsp_pkg::CH_E)
                            begin
                                if (!hseen || eseen) fail(orsp_pkg::ERR_ORDER);
                                letter = (c == orsp_pkg::CH_T) ? orsp_pkg::LETTER_T :
                                         (c == orsp_pkg::CH_M) ? orsp_pkg::LETTER_M :
                                                                 orsp_pkg::LETTER_E;
                            end
                            else fail(orsp_pkg::ERR_TYPE);
                            nbuf = '0;
                            nlen = '0;
                            next_field(orsp_pkg::PH_SEP);
                        end
                    end
                    orsp_pkg::PH_BLANK: if (!is_ws(c)) fail(orsp_pkg::ERR_TYPE);
                    orsp_pkg::PH_SEP:
                    begin
                        if (!(c == orsp_pkg::CH_SPACE || c == orsp_pkg::CH_TAB))
                        begin
                            next_field(letter == orsp_pkg::LETTER_H ? orsp_pkg::PH_NAME :
                                       letter == orsp_pkg::LETTER_T ? orsp_pkg::PH_TADDR :
                                       letter == orsp_pkg::LETTER_M ? orsp_pkg::PH_MADDR :
                                                                      orsp_pkg::PH_EADDR);
                            again = 1;
                        end
                    end
                    orsp_pkg::PH_NAME:
                    begin
                        if (is_ws(c)) ph = orsp_pkg::PH_GAP1;
                        else if (nlen >= orsp_pkg::NAME_CHARS)
                        begin
                            next_field(orsp_pkg::PH_HSTART);
                            again = 1;
                        end
                        else
                        begin
                            nbuf |= {40'd0, c} << (8 * (5 - int'(nlen)));
                            nlen++;
                        end
                    end
                    orsp_pkg::PH_GAP1, orsp_pkg::PH_GAP2:
                    begin
                        if (!is_ws(c))
                        begin
                            next_field(ph == orsp_pkg::PH_GAP1 ? orsp_pkg::PH_HSTART
                                                               : orsp_pkg::PH_HLEN);
                            again = 1;
                        end
                    end
                    orsp_pkg::PH_HSTART:
                        if (take_hex(c, 6))
                        begin
                            pstart = fv;
                            next_field(orsp_pkg::PH_GAP2);
                        end
                    orsp_pkg::PH_HLEN:
                        if (take_hex(c, 6))
                        begin
                            plen = fv;
                            hseen = 1;
                            next_field(orsp_pkg::PH_TAIL);
                        end
                    orsp_pkg::PH_TADDR:
                        if (take_hex(c, 6))
                        begin
                            raddr = fv;
                            next_field(orsp_pkg::PH_TCOUNT);
                        end
                    orsp_pkg::PH_TCOUNT:
                        if (take_hex(c, 2))
                        begin
                            rcount = fv[7:0];
                            if (rcount > max_text) fail(orsp_pkg::ERR_TOO_LONG);
                            else if (!in_program(longint'(raddr), 0) ||
                                     !in_program(longint'(raddr) + longint'(rcount), 1))
                                fail(orsp_pkg::ERR_RANGE);
                            next_field(orsp_pkg::PH_TDATA);
                        end
                    orsp_pkg::PH_TDATA:
                    begin
                        if (int'(cnt) >= 2 * int'(rcount)) fail(orsp_pkg::ERR_COUNT);
                        else
                        begin
                            d = hexv(c);
                            if (d > 5'd15) fail(orsp_pkg::ERR_HEX);
                            else
                            begin
                                cnt++;
                                if (cnt[0]) upn = d[3:0];
                                else
                                begin
                                    a = raddr + 24'((cnt - 9'd1) >> 1);
                                    push(orsp_pkg::KIND_BYTE, a, '0, {upn, d[3:0]}, '0, 0,
                                         orsp_pkg::ERR_NONE);
                                end
                            end
                        end
                    end
                    orsp_pkg::PH_MADDR:
                        if (take_hex(c, 6))
                        begin
                            raddr = fv;
                            next_field(orsp_pkg::PH_MNIB);
                        end
                    orsp_pkg::PH_MNIB:
                        if (take_hex(c, 2))
                        begin
                            rcount = fv[7:0];
                            next_field(orsp_pkg::PH_MSIGN);
                        end
                    orsp_pkg::PH_MSIGN:
                    begin
                        if (c != orsp_pkg::CH_PLUS && c != orsp_pkg::CH_MINUS)
                            fail(orsp_pkg::ERR_SIGN);
                        else if (rcount == 8'd0) fail(orsp_pkg::ERR_ZERO_NIB);
                        else if (!in_program(longint'(raddr), 0)) fail(orsp_pkg::ERR_RANGE);
                        minus = (c == orsp_pkg::CH_MINUS);
                        next_field(orsp_pkg::PH_TAIL);
                    end
                    orsp_pkg::PH_EADDR:
                        if (take_hex(c, 6))
                        begin
                            raddr = fv;
                            if (!in_program(longint'(raddr), 0)) fail(orsp_pkg::ERR_RANGE);
                            else eseen = 1;
                            next_field(orsp_pkg::PH_TAIL);
                        end
                    default: ;
                endcase
            end
        endfunction

        function void finish_line();
            if (err == orsp_pkg::ERR_NONE)
            begin
                case (ph)
                    orsp_pkg::PH_START, orsp_pkg::PH_BLANK: ;
                    orsp_pkg::PH_TDATA:
                        if (int'(cnt) != 2 * int'(rcount)) fail(orsp_pkg::ERR_COUNT);
                        else push(orsp_pkg::KIND_TEXT, raddr, {16'd0, rcount}, '0, '0, 0,
                                  orsp_pkg::ERR_NONE);
                    orsp_pkg::PH_TAIL:
                        if (letter == orsp_pkg::LETTER_H)
                            push(orsp_pkg::KIND_HEADER, pstart, plen, '0, nbuf, 0,
                                 orsp_pkg::ERR_NONE);
                        else if (letter == orsp_pkg::LETTER_M)
                            push(orsp_pkg::KIND_MOD, raddr, {16'd0, rcount}, '0, '0, minus,
                                 orsp_pkg::ERR_NONE);
                        else
                            push(orsp_pkg::KIND_END, raddr, '0, '0, '0, 0,
                                 orsp_pkg::ERR_NONE);
                    default: fail(orsp_pkg::ERR_HEX);
                endcase
            end
            ph = orsp_pkg::PH_START; fv = '0; cnt = '0; lead = 0; minus = 0; nlen = '0;
        endfunction

        // accepted character request
        function void note_request(logic [7:0] c, bit eof);
            int before_n;
            before_n = expected_q.size();
            if (eof)
            begin
                finish_line();
                if (err == orsp_pkg::ERR_NONE && (!hseen || !eseen))
                    fail(orsp_pkg::ERR_MISSING);
                push(orsp_pkg::KIND_STATUS, '0, '0, '0, '0, 0, err);
                clear_state();
            end
            else if (c != orsp_pkg::CH_CR && err == orsp_pkg::ERR_NONE)
            begin
                if (c == orsp_pkg::CH_LF) finish_line();
                else take_char(c);
            end
            if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(orsp_pkg::result_t got);
            orsp_pkg::result_t w;
            if (expected_q.size() == 0)
            begin
                report("unexpected result kind", 64'(got.kind), 64'd0);
                return;
            end
            w = expected_q.pop_front();
            if (got.kind !== w.kind) report("result_kind", 64'(got.kind), 64'(w.kind));
            if (got.address !== w.address)
                report("address", 64'(got.address), 64'(w.address));
            if (got.amount !== w.amount) report("amount", 64'(got.amount), 64'(w.amount));
            if (got.data !== w.data) report("data_byte", 64'(got.data), 64'(w.data));
            if (got.name !== w.name) report("program_name", 64'(got.name), 64'(w.name));
            if (got.sub !== w.sub) report("subtract", 64'(got.sub), 64'(w.sub));
            if (got.err !== w.err) report("error_code", 64'(got.err), 64'(w.err));
            if (got.last !== w.last) report("last_of_run", 64'(got.last), 64'(w.last));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        char_valid = 0;
    logic        char_stall;
    logic [7:0]  char_code = 0;
    logic        end_of_file = 0;
    logic        result_valid;
    logic        result_stall = 0;
    logic [2:0]  result_kind;
    logic [23:0] address;
    logic [23:0] amount;
    logic [7:0]  data_byte;
    logic [47:0] program_name;
    logic        subtract;
    logic [3:0]  error_code;
    logic        last_of_run;

    parse_scoreboard sb = new();
    int send_idle = 10;
    int recv_idle = 63;
    int noise_pct = 0;
    int random_sent = 0;
    int quiet_cycles = 0;

    object_record_stream_parser u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .char_valid(char_valid), .char_stall(char_stall), .char_code(char_code),
        .end_of_file(end_of_file), .result_valid(result_valid),
        .result_stall(result_stall), .result_kind(result_kind), .address(address),
        .amount(amount), .data_byte(data_byte), .program_name(program_name),
        .subtract(subtract), .error_code(error_code), .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        orsp_pkg::result_t got;
        if (result_valid && !result_stall)
        begin
            got.kind = result_kind; got.address = address; got.amount = amount;
            got.data = data_byte; got.name = program_name; got.sub = subtract;
            got.err = error_code; got.last = last_of_run;
            sb.check_result(got);
        end
        if (rst_n) result_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("[object_record_stream_parser] ERROR");
            $finish;
        end
    end

    task send_char(logic [7:0] c, bit eof);
        while ($urandom_range(99) < send_idle)
        begin
            char_valid <= 0;
            @(posedge clk);
        end
        char_valid <= 1;
        char_code <= c;
        end_of_file <= eof;
        do @(posedge clk); while (char_stall);
        sb.note_request(c, eof);
    endtask

    // random requests, with optional corruption
    task put(logic [7:0] c);
        if (noise_pct > 0 && $urandom_range(99) < noise_pct) c = 8'($urandom_range(255));
        random_sent++;
        send_char(c, 0);
    endtask

    task put_hex(logic [23:0] v, int n);
        logic [3:0] d;
        for (int i = n - 1; i >= 0; i--)
        begin
            d = 4'(v >> (4 * i));
            if (d < 4'd10) put(8'("0" + d));
            else put(8'(($urandom_range(2) == 0 ? "a" : "A") + d - 8'd10));
        end
    endtask

    task put_eol();
        if ($urandom_range(4) == 0) put(orsp_pkg::CH_CR);
        put(orsp_pkg::CH_LF);
    endtask

    task put_gap();
        case ($urandom_range(5))
            0: put(orsp_pkg::CH_SPACE);
            1: put(orsp_pkg::CH_TAB);
            default: ;
        endcase
    endtask

    task gen_program();
        logic [23:0] start, plen, ofs;
        int nrec, cnt, maxc;
        noise_pct = ($urandom_range(9) < 3) ? 3 : 0;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(10, 40))
                put($urandom_range(5) == 0 ? orsp_pkg::CH_LF : 8'($urandom_range(255)));
            send_char(8'($urandom_range(255)), 1);
            random_sent++;
            return;
        end
        case ($urandom_range(5))
            0: start = 24'(24'hFFFFFF - $urandom_range(300));
            1: start = '0;
            default: start = 24'($urandom_range(24'hFFFFFF));
        endcase
        plen = ($urandom_range(7) == 0) ? 24'd0 : 24'($urandom_range(64, 512));
        if ($urandom_range(3) == 0)
        begin
            put(orsp_pkg::CH_SPACE);
            put(orsp_pkg::CH_VT);
            put_eol();
        end
        put(orsp_pkg::CH_H);
        put_gap();
        repeat ($urandom_range(1, 6)) put(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(1)) put(orsp_pkg::CH_SPACE);
        put_hex(start, 6);
        if ($urandom_range(1)) put(orsp_pkg::CH_FF);
        put_hex(plen, 6);
        put_eol();
        nrec = $urandom_range(0, 4);
        for (int r = 0; r < nrec; r++)
        begin
            maxc = (sb.max_text < 8'd10) ? int'(sb.max_text) : 10;
            cnt = $urandom_range(0, maxc);
            if ($urandom_range(9) == 0 && sb.max_text < 8'd255) cnt = int'(sb.max_text) + 1;
            ofs = (int'(plen) > cnt) ? 24'($urandom_range(int'(plen) - cnt)) : 24'd0;
            put(orsp_pkg::CH_T);
            put_gap();
            put_hex(start + ofs, 6);
            put_hex(24'(cnt), 2);
            for (int i = 0; i < cnt; i++) put_hex(24'($urandom_range(255)), 2);
            put_eol();
        end
        repeat ($urandom_range(0, 2))
        begin
            put(orsp_pkg::CH_M);
            put_hex(24'(start + ((plen > 0) ? $urandom_range(plen - 1) : 0)), 6);
            put_hex(24'($urandom_range(1, 6)), 2);
            put($urandom_range(1) ? orsp_pkg::CH_PLUS : orsp_pkg::CH_MINUS);
            put_eol();
        end
        put(orsp_pkg::CH_E);
        put_hex(24'(start + ((plen > 0) ? $urandom_range(plen - 1) : 0)), 6);
        if ($urandom_range(1)) put_eol();
        send_char(8'($urandom_range(255)), 1);
        random_sent++;
    endtask

    task drain();
        char_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task write_max_text(logic [7:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {orsp_pkg::REG_MAX_TEXT, 2'b00};
        pwdata <= {16'($urandom_range(16'hFFFF)), 8'h0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.max_text = v;
    endtask

    task run_random(int n);
        int goal;
        goal = random_sent + n;
        while (random_sent < goal) gen_program();
        drain();
    endtask

    initial
    begin
        string line;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        line = "HPROG 00000000001\n";
        foreach (line[i]) send_char(line[i], 0);
        line = "E000000\n";
        foreach (line[i]) send_char(line[i], 0);
        send_char(8'hFF, 1);
        drain();
        write_max_text(8'd30);
        send_idle = 10;
        recv_idle = 63;
        run_random(260);
        write_max_text(8'd0);
        send_idle = 63;
        recv_idle = 10;
        run_random(130);
        write_max_text(8'd255);
        run_random(130);
        write_max_text(8'($urandom_range(1, 254)));
        send_idle = 0;
        recv_idle = 0;
        run_random(260);
        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[object_record_stream_parser] OK");
        else
            $display("[object_record_stream_parser] ERROR");
        $finish;
    end
endmodule
